// ===== hw/rtl/npd_pkg.sv =====
// Shared types and constants for the near-pass event detector.
// Holds the beat payloads, the configuration set and the divide-by-1000 reciprocal.
// No dependencies.
`default_nettype none

package npd_pkg;

    localparam int unsigned DIST_W  = 10;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned SEC_W   = 23;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned MAX_DIST_CM_DEF = 765;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STABILITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_DUR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_DUR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GATE      = 3'd4;

    localparam logic [DIST_W-1:0] RST_THRESHOLD = 10'd150;
    localparam logic [MS_W-1:0]   RST_STABILITY = 16'd500;
    localparam logic [MS_W-1:0]   RST_MIN_DUR   = 16'd100;
    localparam logic [MS_W-1:0]   RST_MAX_DUR   = 16'd10000;

    // Multiplying by ceil(2^38 / 1000) and dropping 38 bits is an exact
    // divide by 1000 for every 32-bit operand.
    localparam int unsigned RECIP_SHIFT = 38;
    localparam int unsigned RECIP_W     = 29;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

    typedef struct packed {
        logic [DIST_W-1:0]  range_cm;
        logic [STAMP_W-1:0] stamp_ms;
        logic               predicted_now;
    } t_report;

    typedef struct packed {
        logic [SEC_W-1:0]  start_time_s;
        logic [DIST_W-1:0] closest_cm;
    } t_pass;

    typedef struct packed {
        logic [DIST_W-1:0] near_limit_cm;
        logic [MS_W-1:0]   stability_ms;
        logic [MS_W-1:0]   min_duration_ms;
        logic [MS_W-1:0]   max_duration_ms;
        logic              gate_on_prediction;
    } t_cfg;

    typedef struct packed {
        logic              emit;
        logic [DIST_W-1:0] closest_cm;
    } t_evt;

endpackage

`default_nettype wire

// ===== hw/rtl/npd_beat_if.sv =====
// Valid/ready channel carrying one payload type per beat.
// Depends on nothing; the payload type is set by the instantiating level.
`default_nettype none

interface npd_beat_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/npd_sec_conv.sv =====
// Registered conversion of the entry timestamp from milliseconds to seconds.
// Depends on npd_pkg for the reciprocal constant and widths.
`default_nettype none

module npd_sec_conv (
    input  wire logic                           i_clk,
    input  wire logic [npd_pkg::STAMP_W-1:0]    i_stamp_ms,
    output logic      [npd_pkg::SEC_W-1:0]      o_sec
);
    localparam int unsigned PROD_W = npd_pkg::STAMP_W + npd_pkg::RECIP_W;

    logic [PROD_W-1:0]        w_prod;
    logic [npd_pkg::SEC_W-1:0] r_sec;

    assign w_prod = PROD_W'(i_stamp_ms) * PROD_W'(npd_pkg::RECIP_1000);

    always_ff @(posedge i_clk) begin
        r_sec <= w_prod[npd_pkg::RECIP_SHIFT +: npd_pkg::SEC_W];
    end

    assign o_sec = r_sec;
endmodule

`default_nettype wire

// ===== hw/rtl/npd_fsm.sv =====
// Four-phase pass detector with entry/exit qualification and minimum tracking.
// Depends on npd_pkg for the report, configuration and event types.
`default_nettype none

module npd_fsm #(
    parameter int unsigned MAX_DIST_CM = npd_pkg::MAX_DIST_CM_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire npd_pkg::t_report              i_rpt,
    input  wire npd_pkg::t_cfg                 i_cfg,
    output npd_pkg::t_evt                      o_evt,
    output logic [npd_pkg::STAMP_W-1:0]        o_entry_time
);
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_IN,
        PH_OVER
    } t_phase;

    localparam logic [npd_pkg::DIST_W-1:0] MAX_DIST = npd_pkg::DIST_W'(MAX_DIST_CM);

    t_phase                          r_phase, n_phase;
    logic [npd_pkg::STAMP_W-1:0]     r_entry_time, n_entry_time;
    logic [npd_pkg::STAMP_W-1:0]     r_exit_time, n_exit_time;
    logic [npd_pkg::DIST_W-1:0]      r_nearest, n_nearest;
    logic                            r_pred_entry, n_pred_entry;

    logic                            w_near;
    logic [npd_pkg::DIST_W-1:0]      w_nearest;
    logic [npd_pkg::STAMP_W-1:0]     w_since_entry, w_since_exit, w_dur;
    logic                            w_entry_ok, w_exit_ok, w_dur_ok, w_gate_ok, w_confirm;

    assign w_near        = i_rpt.range_cm <= i_cfg.near_limit_cm;
    assign w_nearest     = (i_rpt.range_cm < r_nearest) ? i_rpt.range_cm : r_nearest;
    assign w_since_entry = i_rpt.stamp_ms - r_entry_time;
    assign w_since_exit  = i_rpt.stamp_ms - r_exit_time;
    assign w_dur         = r_exit_time - r_entry_time;
    assign w_entry_ok    = w_since_entry >= npd_pkg::STAMP_W'(i_cfg.stability_ms);
    assign w_exit_ok     = w_since_exit > npd_pkg::STAMP_W'(i_cfg.stability_ms);
    assign w_dur_ok      = (w_dur >= npd_pkg::STAMP_W'(i_cfg.min_duration_ms))
                        && (w_dur <= npd_pkg::STAMP_W'(i_cfg.max_duration_ms));
    assign w_gate_ok     = !i_cfg.gate_on_prediction || r_pred_entry;
    assign w_confirm     = (r_phase == PH_OVER) && !w_near && w_exit_ok;

    always_comb begin
        n_phase      = r_phase;
        n_entry_time = r_entry_time;
        n_exit_time  = r_exit_time;
        n_pred_entry = r_pred_entry;
        n_nearest    = w_nearest;
        case (r_phase)
            PH_IDLE: begin
                if (w_near) begin
                    n_phase      = PH_START;
                    n_entry_time = i_rpt.stamp_ms;
                    n_pred_entry = i_rpt.predicted_now;
                end
            end
            PH_START: begin
                if (!w_near) begin
                    n_phase = PH_IDLE;
                end else if (w_entry_ok) begin
                    n_phase = PH_IN;
                end
            end
            PH_IN: begin
                if (!w_near) begin
                    n_phase     = PH_OVER;
                    n_exit_time = i_rpt.stamp_ms;
                end
            end
            PH_OVER: begin
                if (w_near) begin
                    n_phase = PH_IN;
                end else if (w_exit_ok) begin
                    n_phase   = PH_IDLE;
                    n_nearest = MAX_DIST;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_entry_time <= '0;
            r_exit_time  <= '0;
            r_nearest    <= MAX_DIST;
            r_pred_entry <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_entry_time <= n_entry_time;
            r_exit_time  <= n_exit_time;
            r_nearest    <= n_nearest;
            r_pred_entry <= n_pred_entry;
        end
    end

    assign o_evt.emit       = w_confirm && w_dur_ok && w_gate_ok;
    assign o_evt.closest_cm = w_nearest;
    assign o_entry_time     = r_entry_time;

    a_emit_only_on_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_evt.emit) |-> (r_phase == PH_OVER && !w_near))
        else $error("pass reported outside a confirmed exit");

    a_nearest_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_confirm) |=> (r_nearest == MAX_DIST && r_phase == PH_IDLE))
        else $error("minimum not rearmed after confirmed exit");

    a_nearest_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !w_confirm) |=> (r_nearest <= $past(r_nearest)))
        else $error("minimum distance grew without an exit");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_phase) && $stable(r_nearest) && $stable(r_entry_time)))
        else $error("detector state moved without a beat");

endmodule

`default_nettype wire

// ===== hw/rtl/near_pass_event_detector.sv =====
// Top level of the near-pass event detector: config registers, input and result registers.
// Depends on npd_pkg, npd_beat_if, npd_fsm and npd_sec_conv.
//
//   Channel   Dir  Beat payload                              Handshake
//   i_rpt     in   range_cm, stamp_ms, predicted_now         valid/ready
//   o_pass    out  start_time_s, closest_cm                  valid/ready
//   i_cfg_*   in   register index and write data             write enable, no wait
//
// A report beat is taken every cycle while ready is high; its result (if any) is registered.
// The detector step runs combinationally between the input register and the result register.
// Synchronous active-low reset sets the phase to idle, the minimum to MAX_DIST_CM and clears all valid flags.
// A held result stalls the detector stage, and the input register then fills and drops ready.
`default_nettype none

module near_pass_event_detector #(
    parameter int unsigned MAX_DIST_CM = npd_pkg::MAX_DIST_CM_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    npd_beat_if.sink                               i_rpt,
    npd_beat_if.source                             o_pass,
    input  wire logic                              i_cfg_we,
    input  wire logic [npd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [npd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    npd_pkg::t_cfg                r_cfg;
    logic                         r_in_valid;
    npd_pkg::t_report             r_in;
    logic                         r_out_valid;
    npd_pkg::t_pass               r_out;

    logic                         w_fire;
    npd_pkg::t_evt                w_evt;
    logic [npd_pkg::STAMP_W-1:0]  w_entry_time;
    logic [npd_pkg::SEC_W-1:0]    w_entry_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_limit_cm      <= npd_pkg::RST_THRESHOLD;
            r_cfg.stability_ms       <= npd_pkg::RST_STABILITY;
            r_cfg.min_duration_ms    <= npd_pkg::RST_MIN_DUR;
            r_cfg.max_duration_ms    <= npd_pkg::RST_MAX_DUR;
            r_cfg.gate_on_prediction <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                npd_pkg::CFG_IDX_THRESHOLD: begin
                    r_cfg.near_limit_cm <= i_cfg_data[npd_pkg::DIST_W-1:0];
                end
                npd_pkg::CFG_IDX_STABILITY: begin
                    r_cfg.stability_ms <= i_cfg_data[npd_pkg::MS_W-1:0];
                end
                npd_pkg::CFG_IDX_MIN_DUR: begin
                    r_cfg.min_duration_ms <= i_cfg_data[npd_pkg::MS_W-1:0];
                end
                npd_pkg::CFG_IDX_MAX_DUR: begin
                    r_cfg.max_duration_ms <= i_cfg_data[npd_pkg::MS_W-1:0];
                end
                npd_pkg::CFG_IDX_GATE: begin
                    r_cfg.gate_on_prediction <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_fire      = r_in_valid && (!r_out_valid || o_pass.ready);
    assign i_rpt.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rpt.ready) begin
            r_in_valid <= i_rpt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rpt.ready && i_rpt.valid) begin
            r_in <= i_rpt.data;
        end
    end

    npd_fsm #(
        .MAX_DIST_CM (MAX_DIST_CM)
    ) u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_rpt        (r_in),
        .i_cfg        (r_cfg),
        .o_evt        (w_evt),
        .o_entry_time (w_entry_time)
    );

    npd_sec_conv u_sec_conv (
        .i_clk      (i_clk),
        .i_stamp_ms (w_entry_time),
        .o_sec      (w_entry_sec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_evt.emit;
        end else if (o_pass.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_evt.emit) begin
            r_out.start_time_s <= w_entry_sec;
            r_out.closest_cm   <= w_evt.closest_cm;
        end
    end

    assign o_pass.valid = r_out_valid;
    assign o_pass.data  = r_out;

endmodule

`default_nettype wire
